### rtl/core/blr_pkg.sv
// Shared constants and types for the line rasterizer.
`default_nettype none
package blr_pkg;
    localparam int unsigned COORD_BITS    = 6;
    localparam int unsigned PIX_BITS      = 6;
    localparam int unsigned GRID_BITS     = 7;
    localparam int unsigned QUEUE_DEPTH   = 2;
    localparam int unsigned APB_ADDR_BITS = 3;
    localparam int unsigned APB_DATA_BITS = 32;

    localparam logic [GRID_BITS-1:0] GRID_WIDTH_RESET  = 7'd42;
    localparam logic [GRID_BITS-1:0] GRID_HEIGHT_RESET = 7'd28;

    typedef enum logic {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } t_reg_index;

    typedef enum logic {
        WALK_IDLE = 1'b0,
        WALK_RUN  = 1'b1
    } t_walk_state;

    typedef struct packed {
        logic [GRID_BITS-1:0] width;
        logic [GRID_BITS-1:0] height;
    } t_grid_cfg;
endpackage
`default_nettype wire

### rtl/core/blr_seg_if.sv
// Segment input channel: valid/ready plus the two endpoints.
`default_nettype none
interface blr_seg_if;
    logic                          valid;
    logic                          ready;
    logic [blr_pkg::PIX_BITS-1:0]  start_x;
    logic [blr_pkg::PIX_BITS-1:0]  start_y;
    logic [blr_pkg::PIX_BITS-1:0]  end_x;
    logic [blr_pkg::PIX_BITS-1:0]  end_y;

    modport source (output valid, output start_x, output start_y,
                    output end_x, output end_y, input ready);
    modport sink   (input valid, input start_x, input start_y,
                    input end_x, input end_y, output ready);
endinterface
`default_nettype wire

### rtl/core/blr_pix_if.sv
// Pixel output channel: valid/ready plus one rasterized point.
`default_nettype none
interface blr_pix_if;
    logic                          valid;
    logic                          ready;
    logic [blr_pkg::PIX_BITS-1:0]  pixel_x;
    logic [blr_pkg::PIX_BITS-1:0]  pixel_y;
    logic                          visible;
    logic                          last_point;

    modport source (output valid, output pixel_x, output pixel_y,
                    output visible, output last_point, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y,
                    input visible, input last_point, output ready);
endinterface
`default_nettype wire

### rtl/core/bresenham_line_rasterizer_core.sv
// Line rasterizer top level: APB grid registers, segment queue and walker.
//
// Usage: segments enter on i_seg (start and end point), a valid/ready
// transaction per segment. Points leave on o_pix, one transaction per lattice
// point from start to end, with a visibility flag against the grid size and
// last_point set on the end point.
// Grid width and height reset to 42 and 28 and are written over the APB port (0x0, 0x4);
// write them only while no segment is in flight, as the block does not enforce this.
// Throughput: a segment gives max(|dx|,|dy|)+1 points, and the walker loads it from
// the queue before its first point; its single error-update step per cycle sets the
// point rate while o_pix does not stall.
// Path: a segment is stored in the queue, loaded into the walker's registers, and its
// first point is then registered in the output register before it leaves on o_pix.
// The front end keeps taking segments into a short queue while the walker
// works. A stalled o_pix holds its point and freezes the walker; once the
// queue is full, i_seg.ready drops.
// Reset clears the queue, the walker state and the output valid.
`default_nettype none
module bresenham_line_rasterizer_core #(
    parameter int unsigned COORD_BITS  = blr_pkg::COORD_BITS,
    parameter int unsigned QUEUE_DEPTH = blr_pkg::QUEUE_DEPTH,
    localparam int unsigned DESC_W     = 6 * COORD_BITS + 2
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    blr_seg_if.sink                            i_seg,
    blr_pix_if.source                          o_pix,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [blr_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [blr_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [blr_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready
);
    logic [blr_pkg::GRID_BITS-1:0] r_grid_width, r_grid_height;
    blr_pkg::t_reg_index           w_reg;
    blr_pkg::t_grid_cfg            w_cfg;
    logic                          w_wr;

    logic              w_push_valid, w_push_ready;
    logic [DESC_W-1:0] w_push_desc;
    logic              w_pop_valid, w_pop_ready;
    logic [DESC_W-1:0] w_pop_desc;

    assign pready = 1'b1;
    assign w_reg  = blr_pkg::t_reg_index'(paddr[2]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= blr_pkg::GRID_WIDTH_RESET;
            r_grid_height <= blr_pkg::GRID_HEIGHT_RESET;
        end else if (w_wr) begin
            unique case (w_reg)
                blr_pkg::REG_GRID_WIDTH:  r_grid_width  <= pwdata[blr_pkg::GRID_BITS-1:0];
                blr_pkg::REG_GRID_HEIGHT: r_grid_height <= pwdata[blr_pkg::GRID_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            blr_pkg::REG_GRID_WIDTH:  prdata = blr_pkg::APB_DATA_BITS'(r_grid_width);
            blr_pkg::REG_GRID_HEIGHT: prdata = blr_pkg::APB_DATA_BITS'(r_grid_height);
            default:                  prdata = '0;
        endcase
    end

    assign w_cfg.width  = r_grid_width;
    assign w_cfg.height = r_grid_height;

    blr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_seg        (i_seg),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_desc       (w_push_desc)
    );

    blr_queue #(
        .WIDTH (DESC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_desc),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_desc)
    );

    blr_walker #(
        .COORD_BITS (COORD_BITS)
    ) u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_desc      (w_pop_desc),
        .i_cfg       (w_cfg),
        .o_pix       (o_pix)
    );
endmodule
`default_nettype wire

### rtl/core/blr_front.sv
// Front end: accepts segments, derives deltas and step directions.
`default_nettype none
module blr_front #(
    parameter int unsigned COORD_BITS = blr_pkg::COORD_BITS,
    localparam int unsigned DESC_W    = 6 * COORD_BITS + 2
) (
    blr_seg_if.sink           i_seg,
    output logic              o_push_valid,
    input  logic              i_push_ready,
    output logic [DESC_W-1:0] o_desc
);
    logic [COORD_BITS-1:0] w_sx, w_sy, w_tx, w_ty, w_dx, w_dy;
    logic                  w_xneg, w_yneg;

    always_comb begin
        w_sx   = COORD_BITS'(i_seg.start_x);
        w_sy   = COORD_BITS'(i_seg.start_y);
        w_tx   = COORD_BITS'(i_seg.end_x);
        w_ty   = COORD_BITS'(i_seg.end_y);
        w_xneg = !(w_sx < w_tx);
        w_yneg = !(w_sy < w_ty);
        w_dx   = w_xneg ? (w_sx - w_tx) : (w_tx - w_sx);
        w_dy   = w_yneg ? (w_sy - w_ty) : (w_ty - w_sy);
    end

    assign o_desc       = {w_sx, w_sy, w_tx, w_ty, w_dx, w_dy, w_xneg, w_yneg};
    assign o_push_valid = i_seg.valid;
    assign i_seg.ready  = i_push_ready;
endmodule
`default_nettype wire

### rtl/core/blr_queue.sv
// Small register FIFO between the front end and the walker.
`default_nettype none
module blr_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = blr_pkg::QUEUE_DEPTH,
    localparam int unsigned PW   = $clog2(DEPTH),
    localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_push, w_pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue occupancy above depth");
`endif
endmodule
`default_nettype wire

### rtl/core/blr_walker.sv
// Back end: Bresenham error walk, one point per cycle to an output register unless o_pix stalls.
`default_nettype none
module blr_walker #(
    parameter int unsigned COORD_BITS = blr_pkg::COORD_BITS,
    localparam int unsigned DESC_W    = 6 * COORD_BITS + 2,
    localparam int unsigned EW        = COORD_BITS + 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_pop_valid,
    output logic               o_pop_ready,
    input  logic [DESC_W-1:0]  i_desc,
    input  blr_pkg::t_grid_cfg i_cfg,
    blr_pix_if.source          o_pix
);
    blr_pkg::t_walk_state  r_state, n_state;
    logic [COORD_BITS-1:0] r_x, r_y, r_tx, r_ty, r_dx, r_dy;
    logic                  r_xneg, r_yneg;
    logic signed [EW-1:0]  r_err;

    logic                  r_out_valid;
    logic [blr_pkg::PIX_BITS-1:0] r_out_x, r_out_y;
    logic                  r_out_vis, r_out_last;

    logic [COORD_BITS-1:0] d_sx, d_sy, d_tx, d_ty, d_dx, d_dy;
    logic                  d_xneg, d_yneg;

    logic                  w_done, w_can_emit, w_emit, w_pop;
    logic signed [EW:0]    w_e2, w_pdx, w_ndy, w_err_sum;
    logic signed [EW:0]    w_init;
    logic                  w_step_x, w_step_y;

    assign {d_sx, d_sy, d_tx, d_ty, d_dx, d_dy, d_xneg, d_yneg} = i_desc;

    assign w_done     = (r_x == r_tx) && (r_y == r_ty);
    assign w_can_emit = !r_out_valid || o_pix.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            blr_pkg::WALK_IDLE: begin
                if (i_pop_valid) begin
                    n_state = blr_pkg::WALK_RUN;
                end
            end
            blr_pkg::WALK_RUN: begin
                if (w_can_emit && w_done) begin
                    n_state = blr_pkg::WALK_IDLE;
                end
            end
            default: n_state = blr_pkg::WALK_IDLE;
        endcase
    end

    always_comb begin
        o_pop_ready = 1'b0;
        w_emit      = 1'b0;
        unique case (r_state)
            blr_pkg::WALK_IDLE: o_pop_ready = 1'b1;
            blr_pkg::WALK_RUN:  w_emit      = w_can_emit;
            default: begin
                o_pop_ready = 1'b0;
                w_emit      = 1'b0;
            end
        endcase
    end

    assign w_pop = i_pop_valid && o_pop_ready;

    always_comb begin
        w_e2      = {r_err, 1'b0};
        w_pdx     = (EW + 1)'($signed({1'b0, r_dx}));
        w_ndy     = -(EW + 1)'($signed({1'b0, r_dy}));
        w_step_x  = (w_e2 >= w_ndy);
        w_step_y  = (w_e2 <= w_pdx);
        w_err_sum = (EW + 1)'(r_err) + (w_step_x ? w_ndy : '0) + (w_step_y ? w_pdx : '0);
        w_init    = (EW + 1)'($signed({1'b0, d_dx})) - (EW + 1)'($signed({1'b0, d_dy}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= blr_pkg::WALK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_x    <= d_sx;
            r_y    <= d_sy;
            r_tx   <= d_tx;
            r_ty   <= d_ty;
            r_dx   <= d_dx;
            r_dy   <= d_dy;
            r_xneg <= d_xneg;
            r_yneg <= d_yneg;
            r_err  <= EW'(w_init);
        end else if (w_emit && !w_done) begin
            r_err <= EW'(w_err_sum);
            if (w_step_x) begin
                r_x <= r_xneg ? r_x - 1'b1 : r_x + 1'b1;
            end
            if (w_step_y) begin
                r_y <= r_yneg ? r_y - 1'b1 : r_y + 1'b1;
            end
        end
        if (w_emit) begin
            r_out_x    <= blr_pkg::PIX_BITS'(r_x);
            r_out_y    <= blr_pkg::PIX_BITS'(r_y);
            r_out_vis  <= (blr_pkg::GRID_BITS'(r_x) < i_cfg.width) &&
                          (blr_pkg::GRID_BITS'(r_y) < i_cfg.height);
            r_out_last <= w_done;
        end
    end

    assign o_pix.valid      = r_out_valid;
    assign o_pix.pixel_x    = r_out_x;
    assign o_pix.pixel_y    = r_out_y;
    assign o_pix.visible    = r_out_vis;
    assign o_pix.last_point = r_out_last;

`ifndef SYNTHESIS
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (r_state == blr_pkg::WALK_RUN))
        else $error("segment loaded but walker not running");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_done) |=> (r_state == blr_pkg::WALK_IDLE) && r_out_valid && r_out_last)
        else $error("final point did not end the walk");
    a_emit_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(r_state == blr_pkg::WALK_RUN))
        else $error("point emitted outside a walk");
`endif
endmodule
`default_nettype wire

### tb/tb_bresenham_line_rasterizer_core.sv
// Self-checking testbench for the line rasterizer, checked against a line predictor.
module tb_bresenham_line_rasterizer_core;
    localparam int unsigned PB          = blr_pkg::PIX_BITS;
    localparam int unsigned GB          = blr_pkg::GRID_BITS;
    localparam int unsigned AB          = blr_pkg::APB_ADDR_BITS;
    localparam int unsigned DB          = blr_pkg::APB_DATA_BITS;
    localparam int          STALL_LIMIT = 3000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          RAND_ITEMS  = 42;

    typedef struct {
        logic [PB-1:0] x;
        logic [PB-1:0] y;
        logic          vis;
        logic          last;
    } t_pixel;

    typedef struct {
        logic [PB-1:0] sx;
        logic [PB-1:0] sy;
        logic [PB-1:0] ex;
        logic [PB-1:0] ey;
        bit            typed;
        logic          vis;
    } t_seg_row;

    typedef struct {
        logic [GB-1:0] w;
        logic [GB-1:0] h;
    } t_grid_set;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [AB-1:0] paddr = '0;
    logic [DB-1:0] pwdata = '0;
    logic [DB-1:0] prdata;
    logic pready;

    blr_seg_if seg_if ();
    blr_pix_if pix_if ();

    bresenham_line_rasterizer_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg_if),
        .o_pix   (pix_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [GB-1:0] grid_w = blr_pkg::GRID_WIDTH_RESET;
    logic [GB-1:0] grid_h = blr_pkg::GRID_HEIGHT_RESET;
    t_pixel pending_pixels[$];
    int pixel_errors = 0;
    int quiet_cycles = 0;
    bit calm = 1'b0;
    bit hold_off_req = 1'b0;
    bit hold_off_taken = 1'b0;
    int hold_off_left = 0;

    t_seg_row directed_rows [21] = '{
        '{6'd0,  6'd0,  6'd0,  6'd0,  1'b1, 1'b1},
        '{6'd63, 6'd63, 6'd63, 6'd63, 1'b1, 1'b0},
        '{6'd41, 6'd27, 6'd41, 6'd27, 1'b1, 1'b1},
        '{6'd42, 6'd27, 6'd42, 6'd27, 1'b1, 1'b0},
        '{6'd41, 6'd28, 6'd41, 6'd28, 1'b1, 1'b0},
        '{6'd0,  6'd0,  6'd63, 6'd0,  1'b0, 1'b0},
        '{6'd63, 6'd0,  6'd0,  6'd0,  1'b0, 1'b0},
        '{6'd0,  6'd0,  6'd0,  6'd63, 1'b0, 1'b0},
        '{6'd0,  6'd63, 6'd0,  6'd0,  1'b0, 1'b0},
        '{6'd0,  6'd0,  6'd63, 6'd63, 1'b0, 1'b0},
        '{6'd63, 6'd63, 6'd0,  6'd0,  1'b0, 1'b0},
        '{6'd0,  6'd63, 6'd63, 6'd0,  1'b0, 1'b0},
        '{6'd63, 6'd0,  6'd0,  6'd63, 1'b0, 1'b0},
        '{6'd0,  6'd0,  6'd63, 6'd20, 1'b0, 1'b0},
        '{6'd63, 6'd20, 6'd0,  6'd0,  1'b0, 1'b0},
        '{6'd5,  6'd0,  6'd20, 6'd63, 1'b0, 1'b0},
        '{6'd20, 6'd63, 6'd5,  6'd0,  1'b0, 1'b0},
        '{6'd10, 6'd10, 6'd11, 6'd12, 1'b0, 1'b0},
        '{6'd30, 6'd30, 6'd29, 6'd31, 1'b0, 1'b0},
        '{6'd21, 6'd42, 6'd42, 6'd21, 1'b0, 1'b0},
        '{6'd0,  6'd0,  6'd1,  6'd1,  1'b0, 1'b0}
    };

    t_grid_set grid_sets [8] = '{
        '{7'd0,   7'd0},
        '{7'd64,  7'd64},
        '{7'd127, 7'd127},
        '{7'd1,   7'd1},
        '{7'd64,  7'd1},
        '{7'd1,   7'd127},
        '{7'd33,  7'd17},
        '{7'd42,  7'd28}
    };

    // all-octant error walk from start to end, one point per step
    function automatic void rasterize_segment(input logic [PB-1:0] sx, input logic [PB-1:0] sy,
                                              input logic [PB-1:0] ex, input logic [PB-1:0] ey);
        logic [PB-1:0] cx;
        logic [PB-1:0] cy;
        logic x_neg;
        logic y_neg;
        logic done;
        int adx;
        int nady;
        int err;
        int e2;
        int n;
        t_pixel p;
        cx = sx;
        cy = sy;
        x_neg = !(sx < ex);
        y_neg = !(sy < ey);
        adx = x_neg ? int'(sx) - int'(ex) : int'(ex) - int'(sx);
        nady = y_neg ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
        err = adx + nady;
        for (n = 0; n < (1 << PB); n++) begin
            done = (cx == ex) && (cy == ey);
            p.x = cx;
            p.y = cy;
            p.vis = ({1'b0, cx} < grid_w) && ({1'b0, cy} < grid_h);
            p.last = done;
            pending_pixels.push_back(p);
            if (done) break;
            e2 = 2 * err;
            if (e2 >= nady) begin
                err += nady;
                cx = x_neg ? cx - 1'b1 : cx + 1'b1;
            end
            if (e2 <= adx) begin
                err += adx;
                cy = y_neg ? cy - 1'b1 : cy + 1'b1;
            end
        end
    endfunction

    // entered and left at a falling edge
    task automatic send_segment(input logic [PB-1:0] sx, input logic [PB-1:0] sy,
                                input logic [PB-1:0] ex, input logic [PB-1:0] ey,
                                input bit typed, input logic vis);
        t_pixel p;
        if (!calm && $urandom_range(99) < 20) begin
            seg_if.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
        seg_if.valid   <= 1'b1;
        seg_if.start_x <= sx;
        seg_if.start_y <= sy;
        seg_if.end_x   <= ex;
        seg_if.end_y   <= ey;
        @(posedge i_clk);
        while (!seg_if.ready) @(posedge i_clk);
        if (typed) begin
            p.x = sx;
            p.y = sy;
            p.vis = vis;
            p.last = 1'b1;
            pending_pixels.push_back(p);
        end else begin
            rasterize_segment(sx, sy, ex, ey);
        end
        @(negedge i_clk);
    endtask

    task automatic write_grid_reg(input blr_pkg::t_reg_index idx, input logic [GB-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AB'(idx) << 2;
        pwdata  <= {(DB - GB)'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == blr_pkg::REG_GRID_WIDTH) grid_w = value;
        else grid_h = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random_segment();
        logic [PB-1:0] sx;
        logic [PB-1:0] sy;
        logic [PB-1:0] ex;
        logic [PB-1:0] ey;
        int t;
        int d;
        sx = PB'($urandom);
        sy = PB'($urandom);
        ex = PB'($urandom);
        ey = PB'($urandom);
        case ($urandom_range(9))
            5, 6, 7: begin
                t = int'(sx) + int'($urandom_range(16)) - 8;
                ex = PB'((t < 0) ? 0 : (t > 63) ? 63 : t);
                t = int'(sy) + int'($urandom_range(16)) - 8;
                ey = PB'((t < 0) ? 0 : (t > 63) ? 63 : t);
            end
            8: begin
                d = $urandom_range(63);
                case ($urandom_range(2))
                    0: ey = sy;
                    1: ex = sx;
                    default: begin
                        sx = PB'($urandom_range(63 - d));
                        sy = PB'($urandom_range(63 - d));
                        ex = sx + PB'(d);
                        ey = sy + PB'(d);
                        if ($urandom_range(1)) {sx, ex} = {ex, sx};
                    end
                endcase
            end
            9: begin
                ex = sx;
                ey = sy;
            end
            default: ;
        endcase
        send_segment(sx, sy, ex, ey, 1'b0, 1'b0);
    endtask

    always @(negedge i_clk) begin
        if (hold_off_req && !hold_off_taken) begin
            hold_off_taken = 1'b1;
            hold_off_left = HOLD_CYCLES;
        end
        if (!i_rst_n) begin
            pix_if.ready <= 1'b0;
        end else if (hold_off_left > 0) begin
            hold_off_left--;
            pix_if.ready <= 1'b0;
        end else if (calm) begin
            pix_if.ready <= 1'b1;
        end else begin
            pix_if.ready <= ($urandom_range(99) >= 20);
        end
    end

    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && pix_if.valid && pix_if.ready) begin
            if (pending_pixels.size() == 0) begin
                pixel_errors++;
                if (pixel_errors <= 10)
                    $display("unexpected pixel x=%0d y=%0d vis=%0b last=%0b",
                             pix_if.pixel_x, pix_if.pixel_y, pix_if.visible, pix_if.last_point);
            end else begin
                want = pending_pixels.pop_front();
                if (pix_if.pixel_x !== want.x || pix_if.pixel_y !== want.y ||
                    pix_if.visible !== want.vis || pix_if.last_point !== want.last) begin
                    pixel_errors++;
                    if (pixel_errors <= 10)
                        $display({"pixel mismatch: exp x=%0d y=%0d vis=%0b last=%0b,",
                                  " got x=%0d y=%0d vis=%0b last=%0b"},
                                 want.x, want.y, want.vis, want.last, pix_if.pixel_x,
                                 pix_if.pixel_y, pix_if.visible, pix_if.last_point);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((seg_if.valid && seg_if.ready) || (pix_if.valid && pix_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int r;
        int ph;
        int k;
        seg_if.valid   = 1'b0;
        seg_if.start_x = '0;
        seg_if.start_y = '0;
        seg_if.end_x   = '0;
        seg_if.end_y   = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (r = 0; r < 21; r++)
            send_segment(directed_rows[r].sx, directed_rows[r].sy, directed_rows[r].ex,
                         directed_rows[r].ey, directed_rows[r].typed, directed_rows[r].vis);
        for (k = 0; k < RAND_ITEMS; k++) send_random_segment();

        for (ph = 0; ph < 8; ph++) begin
            seg_if.valid <= 1'b0;
            wait_drained();
            write_grid_reg(blr_pkg::REG_GRID_WIDTH, grid_sets[ph].w);
            write_grid_reg(blr_pkg::REG_GRID_HEIGHT, grid_sets[ph].h);
            @(negedge i_clk);
            calm = (ph == 5);
            for (k = 0; k < RAND_ITEMS; k++) begin
                if (ph == 3 && k == 4) hold_off_req = 1'b1;
                send_random_segment();
            end
            calm = 1'b0;
        end
        seg_if.valid <= 1'b0;

        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (pixel_errors == 0 && pending_pixels.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/core/blr_pkg.sv
rtl/core/blr_seg_if.sv
rtl/core/blr_pix_if.sv
rtl/core/blr_front.sv
rtl/core/blr_queue.sv
rtl/core/blr_walker.sv
rtl/core/bresenham_line_rasterizer_core.sv
tb/tb_bresenham_line_rasterizer_core.sv
